### sv/fwgs_pkg.sv
package fwgs_pkg;

  // default grid size
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;

  // word field widths
  localparam int POS_X_W   = 6;
  localparam int POS_Y_W   = 5;
  localparam int ACTION_W  = 2;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_WR,
    ST_READ_CAP,
    ST_T_RD_CUR,
    ST_T_LD_CUR,
    ST_T_SWEEP,
    ST_T_WB,
    ST_T_WB_TOP,
    ST_RESP
  } state_e;

  // row read address source
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_BOTTOM,
    RD_ROW,
    RD_ROW_UP
  } rd_sel_e;

  // row write address / data source
  typedef enum logic [1:0] {
    WR_ADD,
    WR_BELOW_DOWN,
    WR_BELOW_ROW
  } wr_sel_e;

  // pending result kind
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_ADD_OK,
    RES_ADD_BAD,
    RES_READ
  } res_sel_e;

  typedef struct packed {
    logic     latch_item;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     clear_all;
    logic     cap_below;
    logic     cap_cur;
    logic     row_init;
    logic     row_dec;
    logic     col_init;
    logic     sweep_step;
    logic     shift_rows;
    logic     res_set;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    interior;
    logic    in_range;
    logic    col_last;
    logic    row_zero;
  } status_t;

endpackage

### sv/falling_water_grid_step_top.sv
// One word at a time; the next word is taken the cycle after the result is
// loaded into the output register. A tick sweeps the grid one cell per cycle
// through the row pair registers, with one load and one store per row.
// Reset (rst_ni low, asynchronous): grid empty, no result pending, idle.
module falling_water_grid_step_top #(
  parameter int GridWidth  = fwgs_pkg::GRID_WIDTH,
  parameter int GridHeight = fwgs_pkg::GRID_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input word
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [5:0] pos_x, [10:6] pos_y, [15:11] zero
  input  logic [fwgs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] action
  input  logic [fwgs_pkg::ACTION_W-1:0]  s_axis_tuser,
  // result word
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] cell_full, [1] accepted, [7:2] zero
  output logic [fwgs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  fwgs_pkg::cmd_t    cmd;
  fwgs_pkg::status_t status;
  logic              cell_full, accepted;

  // controller: sequences add, read, clear and the row-pair tick sweep
  fwgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: row store, row pair registers, counters, result registers
  fwgs_datapath #(
    .GridWidth  (GridWidth),
    .GridHeight (GridHeight)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .action_i    (fwgs_pkg::action_e'(s_axis_tuser)),
    .pos_x_i     (s_axis_tdata[fwgs_pkg::POS_X_W-1:0]),
    .pos_y_i     (s_axis_tdata[fwgs_pkg::POS_X_W+fwgs_pkg::POS_Y_W-1:fwgs_pkg::POS_X_W]),
    .status_o    (status),
    .cell_full_o (cell_full),
    .accepted_o  (accepted)
  );

  assign m_axis_tdata = {{(fwgs_pkg::M_TDATA_W-2){1'b0}}, accepted, cell_full};

endmodule

### sv/fwgs_ctrl.sv
module fwgs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fwgs_pkg::status_t status_i,
  output fwgs_pkg::cmd_t    cmd_o
);

  fwgs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwgs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      fwgs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = fwgs_pkg::ST_DISPATCH;
        end
      end
      fwgs_pkg::ST_DISPATCH: begin
        unique case (status_i.action)
          fwgs_pkg::ACT_ADD: begin
            if (status_i.interior) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = fwgs_pkg::RD_ITEM;
              state_d      = fwgs_pkg::ST_ADD_WR;
            end else begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_sel = fwgs_pkg::RES_ADD_BAD;
              state_d       = fwgs_pkg::ST_RESP;
            end
          end
          fwgs_pkg::ACT_TICK: begin
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_sel   = fwgs_pkg::RD_BOTTOM;
            cmd_o.row_init = 1'b1;
            state_d        = fwgs_pkg::ST_T_RD_CUR;
          end
          fwgs_pkg::ACT_READ: begin
            if (status_i.in_range) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = fwgs_pkg::RD_ITEM;
              state_d      = fwgs_pkg::ST_READ_CAP;
            end else begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_sel = fwgs_pkg::RES_PLAIN;
              state_d       = fwgs_pkg::ST_RESP;
            end
          end
          default: begin
            cmd_o.clear_all = 1'b1;
            cmd_o.res_set   = 1'b1;
            cmd_o.res_sel   = fwgs_pkg::RES_PLAIN;
            state_d         = fwgs_pkg::ST_RESP;
          end
        endcase
      end
      fwgs_pkg::ST_ADD_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = fwgs_pkg::WR_ADD;
        cmd_o.res_set = 1'b1;
        cmd_o.res_sel = fwgs_pkg::RES_ADD_OK;
        state_d       = fwgs_pkg::ST_RESP;
      end
      fwgs_pkg::ST_READ_CAP: begin
        cmd_o.res_set = 1'b1;
        cmd_o.res_sel = fwgs_pkg::RES_READ;
        state_d       = fwgs_pkg::ST_RESP;
      end
      fwgs_pkg::ST_T_RD_CUR: begin
        cmd_o.cap_below = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = fwgs_pkg::RD_ROW;
        state_d         = fwgs_pkg::ST_T_LD_CUR;
      end
      fwgs_pkg::ST_T_LD_CUR: begin
        cmd_o.cap_cur  = 1'b1;
        cmd_o.col_init = 1'b1;
        state_d        = fwgs_pkg::ST_T_SWEEP;
      end
      fwgs_pkg::ST_T_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.col_last) begin
          state_d = fwgs_pkg::ST_T_WB;
        end
      end
      fwgs_pkg::ST_T_WB: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_sel     = fwgs_pkg::WR_BELOW_DOWN;
        cmd_o.shift_rows = 1'b1;
        if (status_i.row_zero) begin
          state_d = fwgs_pkg::ST_T_WB_TOP;
        end else begin
          cmd_o.row_dec = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_sel  = fwgs_pkg::RD_ROW_UP;
          state_d       = fwgs_pkg::ST_T_LD_CUR;
        end
      end
      fwgs_pkg::ST_T_WB_TOP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = fwgs_pkg::WR_BELOW_ROW;
        cmd_o.res_set = 1'b1;
        cmd_o.res_sel = fwgs_pkg::RES_PLAIN;
        state_d       = fwgs_pkg::ST_RESP;
      end
      fwgs_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = fwgs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fwgs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/fwgs_datapath.sv
module fwgs_datapath #(
  parameter int GridWidth  = fwgs_pkg::GRID_WIDTH,
  parameter int GridHeight = fwgs_pkg::GRID_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fwgs_pkg::cmd_t               cmd_i,
  input  fwgs_pkg::action_e            action_i,
  input  logic [fwgs_pkg::POS_X_W-1:0] pos_x_i,
  input  logic [fwgs_pkg::POS_Y_W-1:0] pos_y_i,
  output fwgs_pkg::status_t            status_o,
  output logic                         cell_full_o,
  output logic                         accepted_o
);

  localparam int COL_W = $clog2(GridWidth);
  localparam int ROW_W = $clog2(GridHeight);

  // row store and per-row valid bits (an invalid row reads as empty)
  logic [GridWidth-1:0]  mem [GridHeight];
  logic [GridHeight-1:0] valid_q;
  logic [GridWidth-1:0]  rd_q;
  logic                  rdv_q;

  fwgs_pkg::action_e            act_q;
  logic [fwgs_pkg::POS_X_W-1:0] px_q;
  logic [fwgs_pkg::POS_Y_W-1:0] py_q;

  logic [ROW_W-1:0]     row_q;
  logic [COL_W-1:0]     col_q;
  logic [GridWidth-1:0] cur_q, below_q;
  logic                 res_full_q, res_acc_q;
  logic                 out_full_q, out_acc_q;

  logic [COL_W-1:0]     x_idx, col_l, col_r;
  logic [ROW_W-1:0]     y_row, rd_addr, wr_addr;
  logic [GridWidth-1:0] eff_row, wr_data, cur_n, below_n;

  assign x_idx   = COL_W'(px_q);
  assign y_row   = ROW_W'(py_q);
  assign eff_row = rdv_q ? rd_q : '0;
  assign col_l   = col_q - 1'b1;
  assign col_r   = col_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      act_q <= action_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
    end
  end

  always_comb begin
    rd_addr = row_q;
    unique case (cmd_i.rd_sel)
      fwgs_pkg::RD_ITEM:   rd_addr = y_row;
      fwgs_pkg::RD_BOTTOM: rd_addr = ROW_W'(GridHeight - 1);
      fwgs_pkg::RD_ROW:    rd_addr = row_q;
      fwgs_pkg::RD_ROW_UP: rd_addr = row_q - 1'b1;
      default:             rd_addr = row_q;
    endcase
  end

  always_comb begin
    wr_addr = row_q;
    wr_data = below_q;
    unique case (cmd_i.wr_sel)
      fwgs_pkg::WR_ADD: begin
        wr_addr = y_row;
        wr_data = eff_row | (GridWidth'(1) << x_idx);
      end
      fwgs_pkg::WR_BELOW_DOWN: wr_addr = row_q + 1'b1;
      fwgs_pkg::WR_BELOW_ROW:  wr_addr = row_q;
      default:                 wr_addr = row_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rdv_q <= valid_q[rd_addr];
      end
    end
  end

  // one cell of the sweep: down, else down-left, else down-right
  always_comb begin
    cur_n   = cur_q;
    below_n = below_q;
    if (cur_q[col_q]) begin
      if (!below_q[col_q]) begin
        below_n[col_q] = 1'b1;
        cur_n[col_q]   = 1'b0;
      end else if (!below_q[col_l]) begin
        below_n[col_l] = 1'b1;
        cur_n[col_q]   = 1'b0;
      end else if (!below_q[col_r]) begin
        below_n[col_r] = 1'b1;
        cur_n[col_q]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      row_q <= ROW_W'(GridHeight - 2);
    end else if (cmd_i.row_dec) begin
      row_q <= row_q - 1'b1;
    end
    if (cmd_i.col_init) begin
      col_q <= COL_W'(1);
    end else if (cmd_i.sweep_step) begin
      col_q <= col_r;
    end
    if (cmd_i.cap_below) begin
      below_q <= eff_row;
    end else if (cmd_i.sweep_step) begin
      below_q <= below_n;
    end else if (cmd_i.shift_rows) begin
      below_q <= cur_q;
    end
    if (cmd_i.cap_cur) begin
      cur_q <= eff_row;
    end else if (cmd_i.sweep_step) begin
      cur_q <= cur_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      unique case (cmd_i.res_sel)
        fwgs_pkg::RES_ADD_OK: begin
          res_full_q <= 1'b0;
          res_acc_q  <= 1'b1;
        end
        fwgs_pkg::RES_ADD_BAD: begin
          res_full_q <= 1'b0;
          res_acc_q  <= 1'b0;
        end
        fwgs_pkg::RES_READ: begin
          res_full_q <= eff_row[x_idx];
          res_acc_q  <= 1'b1;
        end
        default: begin
          res_full_q <= 1'b0;
          res_acc_q  <= 1'b1;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_full_q <= res_full_q;
      out_acc_q  <= res_acc_q;
    end
  end

  assign status_o.action   = act_q;
  assign status_o.interior = (px_q != '0) && ((int'(px_q) + 1) < GridWidth)
                          && (py_q != '0) && ((int'(py_q) + 1) < GridHeight);
  assign status_o.in_range = (int'(px_q) < GridWidth) && (int'(py_q) < GridHeight);
  assign status_o.col_last = (col_q == COL_W'(GridWidth - 2));
  assign status_o.row_zero = (row_q == '0);

  assign cell_full_o = out_full_q;
  assign accepted_o  = out_acc_q;

endmodule

### sv/fwgs_checker.sv
module fwgs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fwgs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // one word at a time: busy right after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after acceptance");

  // no result can appear the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result word too early");

  // a full cell is only reported together with accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("cell_full without accepted");

endmodule

bind falling_water_grid_step_top fwgs_checker u_fwgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb_falling_water_grid_step_top.sv
`timescale 1ns / 100ps

module tb_falling_water_grid_step_top;

  localparam int IdlePct    = 14;   // chance in a hundred that a side idles
  localparam int RandWords  = 268;  // random words after the directed rows
  localparam int NumRows    = 22;
  localparam int PauseAt    = 100;  // sender waits for the pipe to drain here
  localparam int QuietLo    = 150;  // window with no idling on either side
  localparam int QuietHi    = 210;
  localparam int HoldAt     = 40;   // results seen before the long hold-off
  localparam int HoldCycles = 400;
  localparam int TailCycles = 50;

  typedef struct packed {
    logic accepted;
    logic cell_full;
  } result_t;

  typedef struct packed {
    fwgs_pkg::action_e            act;
    logic [fwgs_pkg::POS_X_W-1:0] x;
    logic [fwgs_pkg::POS_Y_W-1:0] y;
    logic                         typed;  // expected result written out in the row
    logic                         full;
    logic                         acc;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [fwgs_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [fwgs_pkg::ACTION_W-1:0]  s_axis_tuser  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [fwgs_pkg::M_TDATA_W-1:0] m_axis_tdata;

  // Shadow of the water grid, one row word per row, bit x is column x
  logic [fwgs_pkg::GRID_WIDTH-1:0] water_rows [fwgs_pkg::GRID_HEIGHT];
  result_t                         pending_results [$];

  int   error_count  = 0;
  int   words_sent   = 0;
  int   results_seen = 0;
  logic held_off     = 1'b0;

  falling_water_grid_step_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset held low from time zero, released on a falling edge, never again
  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------
  function automatic void clear_water();
    for (int r = 0; r < fwgs_pkg::GRID_HEIGHT; r++) water_rows[r] = '0;
  endfunction

  // One tick: bottom-but-one row up to the top, columns left to right,
  // updated in place so earlier moves in a row affect later cells.
  function automatic void tick_water();
    for (int r = fwgs_pkg::GRID_HEIGHT - 2; r >= 0; r--) begin
      for (int c = 1; c <= fwgs_pkg::GRID_WIDTH - 2; c++) begin
        if (water_rows[r][c]) begin
          if (!water_rows[r+1][c]) begin
            water_rows[r+1][c] = 1'b1;
            water_rows[r][c]   = 1'b0;
          end else if (!water_rows[r+1][c-1]) begin
            water_rows[r+1][c-1] = 1'b1;
            water_rows[r][c]     = 1'b0;
          end else if (!water_rows[r+1][c+1]) begin
            water_rows[r+1][c+1] = 1'b1;
            water_rows[r][c]     = 1'b0;
          end
        end
      end
    end
  endfunction

  function automatic result_t apply_word(fwgs_pkg::action_e act, int x, int y);
    result_t res;
    res.cell_full = 1'b0;
    res.accepted  = 1'b1;
    case (act)
      fwgs_pkg::ACT_ADD: begin
        // only interior cells take water; border and beyond are refused
        if (x > 0 && x + 1 < fwgs_pkg::GRID_WIDTH &&
            y > 0 && y + 1 < fwgs_pkg::GRID_HEIGHT) begin
          water_rows[y][x] = 1'b1;
        end else begin
          res.accepted = 1'b0;
        end
      end
      fwgs_pkg::ACT_TICK: begin
        tick_water();
      end
      fwgs_pkg::ACT_READ: begin
        if (x < fwgs_pkg::GRID_WIDTH && y < fwgs_pkg::GRID_HEIGHT)
          res.cell_full = water_rows[y][x];
      end
      default: begin
        clear_water();
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Entered and left on a falling edge; one assignment per signal per edge.
  task automatic send_word(input fwgs_pkg::action_e act,
                           input logic [fwgs_pkg::POS_X_W-1:0] x,
                           input logic [fwgs_pkg::POS_Y_W-1:0] y, input logic typed,
                           input result_t typed_res);
    result_t pred;
    while (!(words_sent >= QuietLo && words_sent < QuietHi) &&
           $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(fwgs_pkg::S_TDATA_W-fwgs_pkg::POS_X_W-fwgs_pkg::POS_Y_W){1'b0}},
                      y, x};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_word(act, int'(x), int'(y));
    pending_results.push_back(typed ? typed_res : pred);
    words_sent++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    stim_row_t                    rows [NumRows];
    int                           roll;
    fwgs_pkg::action_e            act;
    logic [fwgs_pkg::POS_X_W-1:0] x;
    logic [fwgs_pkg::POS_Y_W-1:0] y;

    rows = '{
      // empty grid after reset, both corners
      '{fwgs_pkg::ACT_READ,  6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_READ,  6'd63, 5'd31, 1'b1, 1'b0, 1'b1},
      // adds on each border are refused
      '{fwgs_pkg::ACT_ADD,   6'd0,  5'd5,  1'b1, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_ADD,   6'd63, 5'd5,  1'b1, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_ADD,   6'd5,  5'd0,  1'b1, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_ADD,   6'd5,  5'd31, 1'b1, 1'b0, 1'b0},
      // interior extremes
      '{fwgs_pkg::ACT_ADD,   6'd1,  5'd1,  1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_ADD,   6'd62, 5'd30, 1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_READ,  6'd1,  5'd1,  1'b1, 1'b1, 1'b1},
      // straight fall into the bottom row
      '{fwgs_pkg::ACT_TICK,  6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_READ,  6'd62, 5'd31, 1'b0, 1'b0, 1'b0},
      // blocked below: slide down-left
      '{fwgs_pkg::ACT_ADD,   6'd62, 5'd30, 1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_TICK,  6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      // blocked below and down-left: slide down-right onto the border column
      '{fwgs_pkg::ACT_ADD,   6'd62, 5'd30, 1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_TICK,  6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      // all three blocked: water stays put
      '{fwgs_pkg::ACT_ADD,   6'd62, 5'd30, 1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_TICK,  6'd0,  5'd0,  1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_READ,  6'd63, 5'd31, 1'b0, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_READ,  6'd62, 5'd30, 1'b0, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_READ,  6'd1,  5'd5,  1'b0, 1'b0, 1'b0},
      '{fwgs_pkg::ACT_CLEAR, 6'd63, 5'd31, 1'b1, 1'b0, 1'b1},
      '{fwgs_pkg::ACT_READ,  6'd62, 5'd31, 1'b1, 1'b0, 1'b1}
    };

    clear_water();
    wait (rst_ni);
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_word(rows[i].act, rows[i].x, rows[i].y, rows[i].typed,
                result_t'({rows[i].acc, rows[i].full}));
    end

    // Random part: adds mostly land in a narrow band so piles build up and
    // the diagonal moves get exercised; reads look mostly at the heap.
    for (int n = 0; n < RandWords; n++) begin
      if (words_sent == PauseAt) begin
        while (pending_results.size() != 0) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
        end
      end
      roll = $urandom_range(99);
      x    = fwgs_pkg::POS_X_W'($urandom_range(63));
      y    = fwgs_pkg::POS_Y_W'($urandom_range(31));
      if (roll < 42) begin
        act = fwgs_pkg::ACT_ADD;
        if ($urandom_range(99) < 80) begin
          x = fwgs_pkg::POS_X_W'($urandom_range(34, 26));
          y = fwgs_pkg::POS_Y_W'($urandom_range(20, 1));
        end
      end else if (roll < 54) begin
        act = fwgs_pkg::ACT_TICK;
      end else if (roll < 97) begin
        act = fwgs_pkg::ACT_READ;
        if ($urandom_range(99) < 60) begin
          x = fwgs_pkg::POS_X_W'($urandom_range(38, 22));
          y = fwgs_pkg::POS_Y_W'($urandom_range(31, 18));
        end
      end else begin
        act = fwgs_pkg::ACT_CLEAR;
      end
      send_word(act, x, y, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------
  // Random back-pressure, a quiet window, and one long hold-off while the
  // sender keeps offering so the block backs up onto its input.
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= HoldAt) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        held_off = 1'b1;
      end
      m_axis_tready <= (results_seen >= QuietLo && results_seen < QuietHi) ||
                       ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", int'(m_axis_tdata), -1);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.cell_full)
          report_mismatch("cell_full", int'(m_axis_tdata[0]), int'(want.cell_full));
        if (m_axis_tdata[1] !== want.accepted)
          report_mismatch("accepted", int'(m_axis_tdata[1]), int'(want.accepted));
        if (m_axis_tdata[fwgs_pkg::M_TDATA_W-1:2] !== '0)
          report_mismatch("pad bits", int'(m_axis_tdata[fwgs_pkg::M_TDATA_W-1:2]), 0);
      end
      results_seen++;
    end
  end

endmodule

### sim.f
sv/fwgs_pkg.sv
sv/fwgs_ctrl.sv
sv/fwgs_datapath.sv
sv/falling_water_grid_step_top.sv
sv/fwgs_checker.sv
tb/tb_falling_water_grid_step_top.sv
